FILE: rtl/core/dic_pkg.sv
`default_nettype none
package dic_pkg;

  localparam int unsigned CH_W       = 16;
  localparam int unsigned TOTAL_W    = 9;
  localparam int unsigned SEG_CNT_W  = 4;
  localparam int unsigned SEG_LEN_W  = 7;
  localparam int unsigned ERR_W      = 3;
  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned CFG_ADDR_W = 2;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic [ERR_W-1:0] ERR_NONE    = 3'd0;
  localparam logic [ERR_W-1:0] ERR_LONG    = 3'd1;
  localparam logic [ERR_W-1:0] ERR_COUNT   = 3'd2;
  localparam logic [ERR_W-1:0] ERR_PATTERN = 3'd3;
  localparam logic [ERR_W-1:0] ERR_DOUBLE  = 3'd4;
  localparam logic [ERR_W-1:0] ERR_TRAIL   = 3'd5;

  localparam logic [CFG_ADDR_W-1:0] REG_MIN_SEGMENTS       = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SEGMENTS       = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_TOTAL_LENGTH   = 2'd2;
  localparam logic [CFG_ADDR_W-1:0] REG_MAX_SEGMENT_LENGTH = 2'd3;

  localparam logic [3:0] RST_MIN_SEGMENTS       = 4'd3;
  localparam logic [3:0] RST_MAX_SEGMENTS       = 4'd5;
  localparam logic [7:0] RST_MAX_TOTAL_LENGTH   = 8'd96;
  localparam logic [5:0] RST_MAX_SEGMENT_LENGTH = 6'd32;

  localparam logic [CH_W-1:0] CH_DOT   = 16'h002E;
  localparam logic [CH_W-1:0] CH_UNDER = 16'h005F;
  localparam logic [CH_W-1:0] CH_LO_A  = 16'h0061;
  localparam logic [CH_W-1:0] CH_LO_Z  = 16'h007A;
  localparam logic [CH_W-1:0] CH_D0    = 16'h0030;
  localparam logic [CH_W-1:0] CH_D9    = 16'h0039;

  typedef struct packed {
    logic [3:0] min_segments;
    logic [3:0] max_segments;
    logic [7:0] max_total_length;
    logic [5:0] max_segment_length;
  } cfg_t;

  typedef struct packed {
    logic                 valid_res;
    logic [ERR_W-1:0]     problem;
    logic [SEG_CNT_W-1:0] segment_count;
    logic [SEG_CNT_W-1:0] bad_segment;
  } result_t;

endpackage
`default_nettype wire

FILE: rtl/core/dic_cfg_regs.sv
`default_nettype none
module dic_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [dic_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [dic_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output      dic_pkg::cfg_t                  cfg
);
  import dic_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_segments       <= RST_MIN_SEGMENTS;
      cfg_r.max_segments       <= RST_MAX_SEGMENTS;
      cfg_r.max_total_length   <= RST_MAX_TOTAL_LENGTH;
      cfg_r.max_segment_length <= RST_MAX_SEGMENT_LENGTH;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_MIN_SEGMENTS:       cfg_r.min_segments       <= cfg_wdata[3:0];
        REG_MAX_SEGMENTS:       cfg_r.max_segments       <= cfg_wdata[3:0];
        REG_MAX_TOTAL_LENGTH:   cfg_r.max_total_length   <= cfg_wdata[7:0];
        REG_MAX_SEGMENT_LENGTH: cfg_r.max_segment_length <= cfg_wdata[5:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

FILE: rtl/core/dic_scan.sv
`default_nettype none
module dic_scan (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_fire,
  input  wire logic                     in_end,
  input  wire logic [dic_pkg::CH_W-1:0] in_ch,
  input  wire dic_pkg::cfg_t            cfg,
  output      logic                     res_push,
  output      dic_pkg::result_t         res
);
  import dic_pkg::*;

  logic [TOTAL_W-1:0]   total_length_r,    total_length_nxt;
  logic [SEG_CNT_W-1:0] segments_seen_r,   segments_seen_nxt;
  logic [SEG_LEN_W-1:0] segment_length_r,  segment_length_nxt;
  logic                 first_char_bad_r,  first_char_bad_nxt;
  logic [ERR_W-1:0]     inner_error_r,     inner_error_nxt;
  logic                 prev_underscore_r, prev_underscore_nxt;
  logic [ERR_W-1:0]     latched_error_r,   latched_error_nxt;
  logic [SEG_CNT_W-1:0] latched_index_r,   latched_index_nxt;

  logic                 is_lower, is_digit, is_under, is_dot;
  logic [ERR_W-1:0]     seg_err;
  logic [ERR_W-1:0]     close_error;
  logic [SEG_CNT_W-1:0] close_index;
  logic                 seen_full;
  logic [SEG_CNT_W-1:0] seen_inc;
  logic [SEG_CNT_W-1:0] count;
  logic [ERR_W-1:0]     problem;

  assign is_lower = (in_ch >= CH_LO_A) && (in_ch <= CH_LO_Z);
  assign is_digit = (in_ch >= CH_D0) && (in_ch <= CH_D9);
  assign is_under = (in_ch == CH_UNDER);
  assign is_dot   = (in_ch == CH_DOT);

  assign seen_full = (segments_seen_r == {SEG_CNT_W{1'b1}});
  assign seen_inc  = seen_full ? segments_seen_r : segments_seen_r + 1'b1;

  // Verdict of the segment that a dot or the end beat closes
  always_comb begin
    priority if ((segment_length_r == '0) ||
                 (segment_length_r > {1'b0, cfg.max_segment_length}) ||
                 first_char_bad_r) begin
      seg_err = ERR_PATTERN;
    end else if (inner_error_r != ERR_NONE) begin
      seg_err = inner_error_r;
    end else if (prev_underscore_r) begin
      seg_err = ERR_TRAIL;
    end else begin
      seg_err = ERR_NONE;
    end
  end

  // Keep only the first failing segment
  always_comb begin
    close_error = latched_error_r;
    close_index = latched_index_r;
    if ((seg_err != ERR_NONE) && (latched_error_r == ERR_NONE)) begin
      close_error = seg_err;
      close_index = seen_inc;
    end
  end

  assign count = seen_inc;

  always_comb begin
    priority if (total_length_r > {1'b0, cfg.max_total_length}) begin
      problem = ERR_LONG;
    end else if (seen_full || (count < cfg.min_segments) ||
                 (count > cfg.max_segments)) begin
      problem = ERR_COUNT;
    end else begin
      problem = close_error;
    end
  end

  always_comb begin
    res.valid_res     = (problem == ERR_NONE);
    res.problem       = problem;
    res.segment_count = count;
    res.bad_segment   = ((problem == ERR_PATTERN) || (problem == ERR_DOUBLE) ||
                         (problem == ERR_TRAIL)) ? close_index : '0;
  end

  assign res_push = in_fire && in_end;

  always_comb begin
    total_length_nxt    = total_length_r;
    segments_seen_nxt   = segments_seen_r;
    segment_length_nxt  = segment_length_r;
    first_char_bad_nxt  = first_char_bad_r;
    inner_error_nxt     = inner_error_r;
    prev_underscore_nxt = prev_underscore_r;
    latched_error_nxt   = latched_error_r;
    latched_index_nxt   = latched_index_r;
    if (in_end) begin
      // drop everything after the verdict
      total_length_nxt    = '0;
      segments_seen_nxt   = '0;
      segment_length_nxt  = '0;
      first_char_bad_nxt  = 1'b0;
      inner_error_nxt     = ERR_NONE;
      prev_underscore_nxt = 1'b0;
      latched_error_nxt   = ERR_NONE;
      latched_index_nxt   = '0;
    end else begin
      if (total_length_r != {TOTAL_W{1'b1}}) begin
        total_length_nxt = total_length_r + 1'b1;
      end
      if (is_dot) begin
        latched_error_nxt   = close_error;
        latched_index_nxt   = close_index;
        segments_seen_nxt   = seen_inc;
        segment_length_nxt  = '0;
        first_char_bad_nxt  = 1'b0;
        inner_error_nxt     = ERR_NONE;
        prev_underscore_nxt = 1'b0;
      end else begin
        if (segment_length_r == '0) begin
          first_char_bad_nxt = !is_lower;
        end else if (inner_error_r == ERR_NONE) begin
          priority if (!is_lower && !is_digit && !is_under) begin
            inner_error_nxt = ERR_PATTERN;
          end else if (is_under && prev_underscore_r) begin
            inner_error_nxt = ERR_DOUBLE;
          end else begin
            inner_error_nxt = ERR_NONE;
          end
        end
        prev_underscore_nxt = is_under;
        if (segment_length_r != {SEG_LEN_W{1'b1}}) begin
          segment_length_nxt = segment_length_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_length_r    <= '0;
      segments_seen_r   <= '0;
      segment_length_r  <= '0;
      first_char_bad_r  <= 1'b0;
      inner_error_r     <= ERR_NONE;
      prev_underscore_r <= 1'b0;
      latched_error_r   <= ERR_NONE;
      latched_index_r   <= '0;
    end else if (in_fire) begin
      total_length_r    <= total_length_nxt;
      segments_seen_r   <= segments_seen_nxt;
      segment_length_r  <= segment_length_nxt;
      first_char_bad_r  <= first_char_bad_nxt;
      inner_error_r     <= inner_error_nxt;
      prev_underscore_r <= prev_underscore_nxt;
      latched_error_r   <= latched_error_nxt;
      latched_index_r   <= latched_index_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/dic_out_buf.sv
`default_nettype none
module dic_out_buf (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire dic_pkg::result_t push_data,
  output      logic             room,
  output      logic             out_valid,
  input  wire logic             out_ready,
  output      dic_pkg::result_t out_data
);
  import dic_pkg::*;

  logic    main_valid_r, skid_valid_r;
  result_t main_data_r,  skid_data_r;
  logic    pop;

  assign pop = main_valid_r && out_ready;

  // Control: a push only arrives while the skid slot is empty
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (push) begin
        if (!main_valid_r || pop) begin
          main_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (pop) begin
        main_valid_r <= skid_valid_r;
        skid_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      if (!main_valid_r || pop) begin
        main_data_r <= push_data;
      end else begin
        skid_data_r <= push_data;
      end
    end else if (pop && skid_valid_r) begin
      main_data_r <= skid_data_r;
    end
  end

  assign room      = !skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_data  = main_data_r;

endmodule
`default_nettype wire

FILE: rtl/core/dotted_identifier_checker.sv
// An end beat's verdict is registered into the output buffer by the edge that accepts the beat.
// Throughput: one input beat per cycle while in_tready is high; character beats give no output beat.
// A two-entry output buffer keeps in_tready high while one verdict waits downstream.
// Reset: rst_n, synchronous and active low, clears all scan state, the output buffer,
// and loads the limits with 3, 5, 96 and 32.
`default_nettype none
module dotted_identifier_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output      logic                           in_tready,
  input  wire logic [dic_pkg::CH_W-1:0]       in_tdata,  // [15:0] ch
  input  wire logic                           in_tuser,  // [0] func: 0 character, 1 end
  output      logic                           out_tvalid,
  input  wire logic                           out_tready,
  // [0] valid_res, [3:1] problem, [7:4] segment_count, [11:8] bad_segment, [15:12] zero
  output      logic [dic_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [dic_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [dic_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import dic_pkg::*;

  cfg_t    cfg;
  result_t scan_res;
  result_t buf_res;
  logic    res_push;
  logic    in_fire;

  assign in_fire = in_tvalid && in_tready;

  dic_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  dic_scan u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .in_end   (in_tuser),
    .in_ch    (in_tdata),
    .cfg      (cfg),
    .res_push (res_push),
    .res      (scan_res)
  );

  dic_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (scan_res),
    .room      (in_tready),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (buf_res)
  );

  assign out_tdata = {{(OUT_DATA_W - $bits(result_t)){1'b0}},
                      buf_res.bad_segment, buf_res.segment_count,
                      buf_res.problem, buf_res.valid_res};

endmodule
`default_nettype wire

FILE: sim/dic_verdict_checker.sv
module dic_verdict_checker (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  input  wire logic                           in_tready,
  input  wire logic [dic_pkg::CH_W-1:0]       in_tdata,
  input  wire logic                           in_tuser,
  input  wire logic                           out_tvalid,
  input  wire logic                           out_tready,
  input  wire logic [dic_pkg::OUT_DATA_W-1:0] out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [dic_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [dic_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                                  fail_count,
  output int                                  verdicts_owed,
  output int                                  verdicts_checked
);
  import dic_pkg::*;

  cfg_t                 limits;
  logic [TOTAL_W-1:0]   total_len;
  logic [SEG_CNT_W-1:0] dots_seen;
  logic [SEG_LEN_W-1:0] seg_len;
  logic                 first_bad;
  logic [ERR_W-1:0]     seg_fault;
  logic                 last_us;
  logic [ERR_W-1:0]     first_fault;
  logic [SEG_CNT_W-1:0] first_fault_seg;
  result_t              pending_verdicts[$];

  initial begin
    fail_count = 0;
    verdicts_owed = 0;
    verdicts_checked = 0;
  end

  function automatic logic is_lower(input logic [CH_W-1:0] c);
    return c >= CH_LO_A && c <= CH_LO_Z;
  endfunction

  function automatic logic is_digit(input logic [CH_W-1:0] c);
    return c >= CH_D0 && c <= CH_D9;
  endfunction

  task automatic report_mismatch(input string what, input logic [15:0] got,
                                 input logic [15:0] want);
    $display("%0t: %s mismatch on verdict %0d: got %0h, expected %0h",
             $time, what, verdicts_checked, got, want);
    fail_count++;
  endtask

  task automatic clear_segment();
    seg_len = '0;
    first_bad = 1'b0;
    seg_fault = ERR_NONE;
    last_us = 1'b0;
  endtask

  task automatic clear_scan();
    total_len = '0;
    dots_seen = '0;
    first_fault = ERR_NONE;
    first_fault_seg = '0;
    clear_segment();
  endtask

  // keep only the first failing segment; the length limit applies at close
  task automatic finish_segment();
    logic [ERR_W-1:0] err;
    err = ERR_NONE;
    if (seg_len == 0 || seg_len > {1'b0, limits.max_segment_length} || first_bad)
      err = ERR_PATTERN;
    else if (seg_fault != ERR_NONE)
      err = seg_fault;
    else if (last_us)
      err = ERR_TRAIL;
    if (err != ERR_NONE && first_fault == ERR_NONE) begin
      first_fault = err;
      first_fault_seg = (dots_seen < 4'd15) ? dots_seen + 4'd1 : 4'd15;
    end
    clear_segment();
  endtask

  task automatic scan_char(input logic [CH_W-1:0] c);
    if (total_len < 9'd511)
      total_len = total_len + 1'b1;
    if (c == CH_DOT) begin
      finish_segment();
      if (dots_seen < 4'd15)
        dots_seen = dots_seen + 1'b1;
    end else begin
      if (seg_len == 0) begin
        first_bad = !is_lower(c);
      end else if (seg_fault == ERR_NONE) begin
        if (!is_lower(c) && !is_digit(c) && c != CH_UNDER)
          seg_fault = ERR_PATTERN;
        else if (c == CH_UNDER && last_us)
          seg_fault = ERR_DOUBLE;
      end
      last_us = (c == CH_UNDER);
      if (seg_len < 7'd127)
        seg_len = seg_len + 1'b1;
    end
  endtask

  task automatic close_ident();
    logic                 overflow;
    logic [SEG_CNT_W-1:0] count;
    logic [ERR_W-1:0]     prob;
    logic [SEG_CNT_W-1:0] bad;
    result_t              r;
    finish_segment();
    overflow = (dots_seen == 4'd15);
    count = overflow ? 4'd15 : dots_seen + 4'd1;
    bad = '0;
    if (total_len > {1'b0, limits.max_total_length}) begin
      prob = ERR_LONG;
    end else if (overflow || count < limits.min_segments || count > limits.max_segments) begin
      prob = ERR_COUNT;
    end else begin
      prob = first_fault;
      if (prob != ERR_NONE)
        bad = first_fault_seg;
    end
    r.valid_res = (prob == ERR_NONE);
    r.problem = prob;
    r.segment_count = count;
    r.bad_segment = bad;
    pending_verdicts.push_back(r);
    clear_scan();
  endtask

  task automatic check_verdict(input logic [OUT_DATA_W-1:0] got);
    result_t want;
    if (pending_verdicts.size() == 0) begin
      report_mismatch("unexpected verdict", got, '0);
      return;
    end
    want = pending_verdicts.pop_front();
    verdicts_checked++;
    if (got[0] !== want.valid_res)
      report_mismatch("valid_res", got[0], want.valid_res);
    if (got[3:1] !== want.problem)
      report_mismatch("problem", got[3:1], want.problem);
    if (got[7:4] !== want.segment_count)
      report_mismatch("segment_count", got[7:4], want.segment_count);
    if (got[11:8] !== want.bad_segment)
      report_mismatch("bad_segment", got[11:8], want.bad_segment);
    if (got[15:12] !== 4'd0)
      report_mismatch("padding", got[15:12], '0);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      limits.min_segments = RST_MIN_SEGMENTS;
      limits.max_segments = RST_MAX_SEGMENTS;
      limits.max_total_length = RST_MAX_TOTAL_LENGTH;
      limits.max_segment_length = RST_MAX_SEGMENT_LENGTH;
      clear_scan();
      pending_verdicts.delete();
    end else begin
      if (out_tvalid && out_tready)
        check_verdict(out_tdata);
      if (cfg_we) begin
        case (cfg_addr)
          REG_MIN_SEGMENTS:       limits.min_segments = cfg_wdata[3:0];
          REG_MAX_SEGMENTS:       limits.max_segments = cfg_wdata[3:0];
          REG_MAX_TOTAL_LENGTH:   limits.max_total_length = cfg_wdata[7:0];
          REG_MAX_SEGMENT_LENGTH: limits.max_segment_length = cfg_wdata[5:0];
          default: ;
        endcase
      end
      // tuser high marks the end beat of an identifier
      if (in_tvalid && in_tready) begin
        if (in_tuser)
          close_ident();
        else
          scan_char(in_tdata);
      end
    end
    verdicts_owed = pending_verdicts.size();
  end

endmodule

FILE: sim/dotted_identifier_checker_tb.sv
module dotted_identifier_checker_tb;
  import dic_pkg::*;

  localparam logic FUNC_CHAR   = 1'b0;
  localparam logic FUNC_END    = 1'b1;
  localparam int   PHASE_BEATS = 45;
  localparam int   HOLD_CYCLES = 80;
  localparam int   DRAIN_WAIT  = 4;

  typedef enum int {
    FAULT_NONE, FAULT_BAD_FIRST, FAULT_BAD_LATER, FAULT_DOUBLE_US,
    FAULT_TRAIL_US, FAULT_EMPTY, FAULT_OVERLONG
  } seg_fault_e;

  logic                  clk        = 1'b0;
  logic                  rst_n      = 1'b0;
  logic                  in_tvalid  = 1'b0;
  logic                  in_tready;
  logic [CH_W-1:0]       in_tdata   = '0;
  logic                  in_tuser   = 1'b0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  cfg_we     = 1'b0;
  logic [CFG_ADDR_W-1:0] cfg_addr   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata  = '0;

  int fails;
  int owed;
  int checked;

  logic       idle_on = 1'b1;
  logic       stall_pending = 1'b0;
  int         beats_sent = 0;
  int         settings_used = 0;
  logic [3:0] lim_min = RST_MIN_SEGMENTS;
  logic [3:0] lim_max = RST_MAX_SEGMENTS;
  logic [5:0] lim_seg = RST_MAX_SEGMENT_LENGTH;

  dotted_identifier_checker uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // [15:0] ch
    .in_tuser   (in_tuser),   // [0] func
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // [0] valid_res, [3:1] problem, [7:4] count, [11:8] bad
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  dic_verdict_checker verdict_chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_we           (cfg_we),
    .cfg_addr         (cfg_addr),
    .cfg_wdata        (cfg_wdata),
    .fail_count       (fails),
    .verdicts_owed    (owed),
    .verdicts_checked (checked)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  initial begin
    #400000;
    $display("dotted_identifier_checker verification failed");
    $finish;
  end

  // receiver: random back-pressure, plus one long hold-off on request
  initial begin
    @(negedge clk);
    forever begin
      if (stall_pending) begin
        stall_pending = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      out_tready <= !(idle_on && $urandom_range(99) < 13);
      @(negedge clk);
    end
  end

  function automatic logic is_good(input logic [CH_W-1:0] c);
    return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_D0 && c <= CH_D9) || c == CH_UNDER;
  endfunction

  function automatic logic [CH_W-1:0] pick_lower();
    return CH_W'($urandom_range(CH_LO_A, CH_LO_Z));
  endfunction

  function automatic logic [CH_W-1:0] pick_tail();
    int roll;
    roll = $urandom_range(9);
    if (roll < 6)
      return pick_lower();
    else if (roll < 8)
      return CH_W'($urandom_range(CH_D0, CH_D9));
    return CH_UNDER;
  endfunction

  function automatic logic [CH_W-1:0] pick_bad();
    logic [CH_W-1:0] c;
    case ($urandom_range(15))
      0: c = CH_LO_A - 1'b1;
      1: c = CH_LO_Z + 1'b1;
      2: c = CH_D0 - 1'b1;
      3: c = CH_D9 + 1'b1;
      4: c = CH_UNDER - 1'b1;
      5: c = 16'h0000;
      6: c = 16'hFFFF;
      default: begin
        c = CH_W'($urandom);
        while (is_good(c) || c == CH_DOT)
          c = CH_W'($urandom);
      end
    endcase
    return c;
  endfunction

  function automatic logic [CH_W-1:0] pick_bad_first();
    case ($urandom_range(3))
      0: return CH_W'($urandom_range(CH_D0, CH_D9));
      1: return CH_UNDER;
      default: return pick_bad();
    endcase
  endfunction

  task automatic send_beat(input logic f, input logic [CH_W-1:0] c);
    while (idle_on && $urandom_range(99) < 13) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= f;
    in_tdata <= c;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++)
      send_beat(FUNC_CHAR, {8'h00, s[i]});
  endtask

  task automatic send_end();
    send_beat(FUNC_END, CH_W'($urandom));
  endtask

  // drop valid, wait out all verdicts, then let the block settle
  task automatic drain();
    in_tvalid <= 1'b0;
    wait (owed == 0);
    @(negedge clk);
    repeat (DRAIN_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] a, input logic [CFG_DATA_W-1:0] d);
    cfg_we <= 1'b1;
    cfg_addr <= a;
    cfg_wdata <= d;
    @(negedge clk);
  endtask

  task automatic set_limits(input logic [7:0] min_v, input logic [7:0] max_v,
                            input logic [7:0] tot_v, input logic [7:0] seg_v);
    write_reg(REG_MIN_SEGMENTS, min_v);
    write_reg(REG_MAX_SEGMENTS, max_v);
    write_reg(REG_MAX_TOTAL_LENGTH, tot_v);
    write_reg(REG_MAX_SEGMENT_LENGTH, seg_v);
    cfg_we <= 1'b0;
    lim_min = min_v[3:0];
    lim_max = max_v[3:0];
    lim_seg = seg_v[5:0];
    settings_used++;
  endtask

  task automatic send_segment(input int len, input seg_fault_e fault);
    int              pos_bad;
    int              pos_us;
    logic            prev_us;
    logic [CH_W-1:0] c;
    pos_bad = (len > 1) ? $urandom_range(1, len - 1) : 1;
    pos_us = (len > 2) ? $urandom_range(1, len - 2) : 1;
    prev_us = 1'b0;
    for (int i = 0; i < len; i++) begin
      if (i == 0) begin
        c = (fault == FAULT_BAD_FIRST) ? pick_bad_first() : pick_lower();
      end else if (fault == FAULT_BAD_LATER && i == pos_bad) begin
        c = pick_bad();
      end else if (fault == FAULT_DOUBLE_US && (i == pos_us || i == pos_us + 1)) begin
        c = CH_UNDER;
      end else if (fault == FAULT_TRAIL_US && i == len - 1) begin
        c = CH_UNDER;
      end else begin
        c = pick_tail();
        if (c == CH_UNDER && (prev_us || i == len - 1))
          c = pick_lower();
      end
      prev_us = (c == CH_UNDER);
      send_beat(FUNC_CHAR, c);
    end
  endtask

  // mostly well-formed identifiers near the count limits, some with one bad segment
  task automatic send_dotted();
    int         nseg;
    int         fault_seg;
    int         len;
    int         span;
    int         lo;
    int         hi;
    int         roll;
    seg_fault_e fault;
    lo = (lim_min == 0) ? 1 : lim_min;
    hi = (lim_max == 0) ? 1 : lim_max;
    if (lo > hi) begin
      roll = lo;
      lo = hi;
      hi = roll;
    end
    roll = $urandom_range(99);
    if (roll < 6)
      nseg = $urandom_range(15, 19);
    else if (roll < 30)
      nseg = $urandom_range(1, 8);
    else
      nseg = $urandom_range(lo, hi);
    fault = FAULT_NONE;
    fault_seg = -1;
    if ($urandom_range(99) < 45) begin
      fault = seg_fault_e'($urandom_range(FAULT_BAD_FIRST, FAULT_OVERLONG));
      fault_seg = $urandom_range(0, nseg - 1);
    end
    span = (lim_seg < 6) ? lim_seg : 6;
    if (span < 1)
      span = 1;
    for (int s = 0; s < nseg; s++) begin
      if (s > 0)
        send_beat(FUNC_CHAR, CH_DOT);
      len = $urandom_range(1, span);
      if (s == fault_seg) begin
        case (fault)
          FAULT_EMPTY:                   len = 0;
          FAULT_OVERLONG:                len = lim_seg + $urandom_range(1, 2);
          FAULT_DOUBLE_US:               if (len < 3) len = 3;
          FAULT_BAD_LATER, FAULT_TRAIL_US: if (len < 2) len = 2;
          default: ;
        endcase
      end
      send_segment(len, (s == fault_seg) ? fault : FAULT_NONE);
    end
    send_end();
  endtask

  task automatic send_noise();
    int n;
    n = $urandom_range(0, 14);
    repeat (n) begin
      case ($urandom_range(4))
        0: send_beat(FUNC_CHAR, pick_lower());
        1: send_beat(FUNC_CHAR, pick_tail());
        2: send_beat(FUNC_CHAR, CH_DOT);
        3: send_beat(FUNC_CHAR, CH_UNDER);
        default: send_beat(FUNC_CHAR, pick_bad());
      endcase
    end
    send_end();
  endtask

  task automatic send_long(input int len, input logic with_dots);
    send_beat(FUNC_CHAR, pick_lower());
    for (int i = 1; i < len; i++) begin
      if (with_dots && $urandom_range(24) == 0)
        send_beat(FUNC_CHAR, CH_DOT);
      else
        send_beat(FUNC_CHAR, pick_tail());
    end
    send_end();
  endtask

  task automatic run_phase(input int quota);
    int start;
    int roll;
    start = beats_sent;
    while (beats_sent - start < quota) begin
      roll = $urandom_range(99);
      if (roll < 77)
        send_dotted();
      else if (roll < 97)
        send_noise();
      else
        send_long($urandom_range(60, 200), 1'b1);
    end
    drain();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;

    // reset limits: valid, empty, double underscore first, wide code
    send_text("a.z0_9.b");
    send_end();
    send_end();
    send_text("x__y.b_.0");
    send_end();
    send_text("a");
    send_beat(FUNC_CHAR, 16'hFFFF);
    send_text(".b.c");
    send_end();
    drain();

    // loose limits; fill the block behind a long output hold-off
    set_limits(8'd1, 8'd15, 8'd255, 8'd63);
    stall_pending = 1'b1;
    repeat (16) begin
      send_beat(FUNC_CHAR, pick_lower());
      send_end();
    end
    // one segment longer than the segment length counter can hold
    send_long(130, 1'b0);
    run_phase(PHASE_BEATS);

    set_limits(8'd1, 8'd1, 8'd1, 8'd1);
    run_phase(PHASE_BEATS);

    idle_on = 1'b0;
    set_limits(8'd15, 8'd15, 8'd255, 8'd63);
    run_phase(PHASE_BEATS);
    idle_on = 1'b1;

    // crossed segment limits
    set_limits(8'd6, 8'd2, 8'd40, 8'd8);
    run_phase(PHASE_BEATS);

    set_limits(8'(RST_MIN_SEGMENTS), 8'(RST_MAX_SEGMENTS), RST_MAX_TOTAL_LENGTH,
               8'(RST_MAX_SEGMENT_LENGTH));
    run_phase(PHASE_BEATS);

    repeat (2) begin
      set_limits(8'($urandom_range(255)), 8'($urandom_range(255)),
                 8'($urandom_range(255)), 8'($urandom_range(255)));
      run_phase(PHASE_BEATS);
    end

    set_limits(8'($urandom_range(1, 15)), 8'($urandom_range(1, 15)),
               8'($urandom_range(1, 255)), 8'($urandom_range(1, 63)));
    run_phase(PHASE_BEATS);

    $display("Sent %0d input beats, checked %0d verdicts over %0d limit settings.",
             beats_sent, checked, settings_used);
    $display("Covered a saturated segment counter, crossed limits and a long output hold-off.");
    if (fails == 0 && owed == 0)
      $display("dotted_identifier_checker verification clean");
    else
      $display("dotted_identifier_checker verification failed");
    $finish;
  end

endmodule
